[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[rtl/v3n_pkg.sv]
// Package with types and constants of the vector normalizer
`default_nettype none
package v3n_pkg;
  localparam int unsigned CompW   = 16;
  localparam int unsigned SumW    = 48;
  localparam int unsigned LenW    = 24;
  localparam int unsigned NumW    = 38;
  localparam int unsigned UnitW   = 16;
  localparam int unsigned SqrtSteps = 24;
  localparam int unsigned DivSteps  = 15;
  localparam int unsigned DepthDefault = SqrtSteps + DivSteps + 2;
  localparam logic [UnitW-1:0] UnitOne = 16'd16384;

  typedef struct packed {
    logic             vld;
    logic             zero;
    logic             unit;
    logic [2:0]       neg;
  } v3n_tag_t;

  typedef struct packed {
    logic [SumW-1:0]   rem;
    logic [LenW-1:0]   root;
    logic [SumW-1:0]   rad;
    logic [CompW-1:0]  mx;
    logic [CompW-1:0]  my;
    logic [CompW-1:0]  mz;
    v3n_tag_t          tag;
  } v3n_sqrt_t;

  typedef struct packed {
    logic [NumW-1:0]  rx;
    logic [NumW-1:0]  ry;
    logic [NumW-1:0]  rz;
    logic [CompW-1:0] qx;
    logic [CompW-1:0] qy;
    logic [CompW-1:0] qz;
    logic [LenW-1:0]  len;
    v3n_tag_t         tag;
  } v3n_div_t;
endpackage
`default_nettype wire

[rtl/v3n_sqrt_cell.sv]
// One digit-recurrence cell of the pipelined square root
`default_nettype none
module v3n_sqrt_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  v3n_pkg::v3n_sqrt_t     cell_i,
  output v3n_pkg::v3n_sqrt_t     cell_o
);
  import v3n_pkg::*;

  v3n_sqrt_t cell_d, cell_q;
  logic vld_q;
  logic [SumW+1:0] trial;
  logic [SumW+1:0] rem2;

  always_comb begin
    cell_d = cell_i;
    rem2   = {cell_i.rem, cell_i.rad[SumW-1 -: 2]};
    trial  = {cell_i.root, 2'b01};
    cell_d.rad = {cell_i.rad[SumW-3:0], 2'b00};
    if (rem2 >= trial) begin
      cell_d.rem  = SumW'(rem2 - trial);
      cell_d.root = {cell_i.root[LenW-2:0], 1'b1};
    end else begin
      cell_d.rem  = SumW'(rem2);
      cell_d.root = {cell_i.root[LenW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cell_d.tag.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  always_comb begin
    cell_o         = cell_q;
    cell_o.tag.vld = vld_q;
  end
endmodule
`default_nettype wire

[rtl/v3n_div_cell.sv]
// One restoring-division cell for three quotients sharing a divisor
`default_nettype none
module v3n_div_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  v3n_pkg::v3n_div_t      cell_i,
  output v3n_pkg::v3n_div_t      cell_o
);
  import v3n_pkg::*;

  v3n_div_t cell_d, cell_q;
  logic vld_q;

  function automatic logic [NumW+CompW:0] div_step(
    input logic [NumW-1:0]  rem,
    input logic [CompW-1:0] quo,
    input logic [LenW-1:0]  den
  );
    logic [NumW:0]   r2;
    logic [NumW:0]   d;
    logic [NumW-1:0] rn;
    logic            bitq;
    r2 = {rem, 1'b0};
    d  = {(NumW+1-LenW)'(0), den} << (DivSteps - 1);
    if (r2 >= d) begin
      rn   = NumW'(r2 - d);
      bitq = 1'b1;
    end else begin
      rn   = NumW'(r2);
      bitq = 1'b0;
    end
    return {rn, quo[CompW-2:0], bitq, 1'b0};
  endfunction

  logic [NumW+CompW:0] sx, sy, sz;

  always_comb begin
    cell_d = cell_i;
    sx = div_step(cell_i.rx, cell_i.qx, cell_i.len);
    sy = div_step(cell_i.ry, cell_i.qy, cell_i.len);
    sz = div_step(cell_i.rz, cell_i.qz, cell_i.len);
    cell_d.rx = sx[NumW+CompW -: NumW];
    cell_d.qx = sx[CompW:1];
    cell_d.ry = sy[NumW+CompW -: NumW];
    cell_d.qy = sy[CompW:1];
    cell_d.rz = sz[NumW+CompW -: NumW];
    cell_d.qz = sz[CompW:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cell_d.tag.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  always_comb begin
    cell_o         = cell_q;
    cell_o.tag.vld = vld_q;
  end
endmodule
`default_nettype wire

[rtl/vector3_normalize.sv]
// Top level of the pipelined 3D vector normalizer
// Accepts one vector per clock (busy stays low) and returns each result
// in order, for one cycle with done_o high. The pipeline is made of a
// 24-cell square-root chain and a 15-cell division chain plus one
// squaring stage and one output stage. Results cannot be held off; the
// receiver must take each one.
`default_nettype none
`include "assert_macros.svh"
module vector3_normalize (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [15:0]          x_in_i,
  input  wire logic signed [15:0]          y_in_i,
  input  wire logic signed [15:0]          z_in_i,
  output logic                             done_o,
  output logic signed [15:0]               unit_x_o,
  output logic signed [15:0]               unit_y_o,
  output logic signed [15:0]               unit_z_o,
  output logic [23:0]                      length_fx_o,
  output logic                             is_unit_o,
  output logic                             zero_vector_o
);
  import v3n_pkg::*;

  logic [CompW-1:0] ax, ay, az;
  v3n_sqrt_t sq_d, sq_q;
  v3n_sqrt_t sq_chain [SqrtSteps+1];
  v3n_div_t  dv_chain [DivSteps+1];
  v3n_div_t  dv_in;
  logic [DepthDefault-1:0] vld_sh_q;
  logic done_q;
  logic [UnitW-1:0] ux_q, uy_q, uz_q;
  logic [LenW-1:0] len_q;
  logic unit_q, zero_q;
  logic units_clr;

  assign busy = 1'b0;
  assign ax = x_in_i[15] ? CompW'(-x_in_i) : CompW'(x_in_i);
  assign ay = y_in_i[15] ? CompW'(-y_in_i) : CompW'(y_in_i);
  assign az = z_in_i[15] ? CompW'(-z_in_i) : CompW'(z_in_i);

  always_comb begin
    sq_d = '0;
    sq_d.mx = ax;
    sq_d.my = ay;
    sq_d.mz = az;
    sq_d.tag.vld = start;
    sq_d.tag.neg = {z_in_i[15], y_in_i[15], x_in_i[15]};
    sq_d.tag.zero = (x_in_i == '0) && (y_in_i == '0) && (z_in_i == '0);
  end

  // squaring stage: three products registered, sum formed next cycle
  logic [31:0] px_q, py_q, pz_q;
  v3n_sqrt_t s0_q;
  logic s0_vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= sq_d.tag.vld;
    end
  end
  always_ff @(posedge clk_i) begin
    px_q <= ax * ax;
    py_q <= ay * ay;
    pz_q <= az * az;
    s0_q <= sq_d;
  end

  logic [33:0] ssum;
  assign ssum = 34'(px_q) + 34'(py_q) + 34'(pz_q);

  always_comb begin
    sq_q = s0_q;
    sq_q.tag.vld = s0_vld_q;
    sq_q.rad = {ssum[31:0], 16'd0};
    sq_q.tag.unit = (ssum == 34'd1);
  end

  assign sq_chain[0] = sq_q;
  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    v3n_sqrt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cell_i(sq_chain[i]),
      .cell_o(sq_chain[i+1])
    );
  end

  always_comb begin
    dv_in = '0;
    dv_in.rx  = NumW'({sq_chain[SqrtSteps].mx, 22'd0}) >> 1;
    dv_in.ry  = NumW'({sq_chain[SqrtSteps].my, 22'd0}) >> 1;
    dv_in.rz  = NumW'({sq_chain[SqrtSteps].mz, 22'd0}) >> 1;
    dv_in.len = sq_chain[SqrtSteps].root;
    dv_in.tag = sq_chain[SqrtSteps].tag;
  end

  assign dv_chain[0] = dv_in;
  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    v3n_div_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cell_i(dv_chain[j]),
      .cell_o(dv_chain[j+1])
    );
  end

  v3n_div_t dv_end;
  logic [UnitW-1:0] qx_s, qy_s, qz_s;
  assign dv_end = dv_chain[DivSteps];

  function automatic logic [UnitW-1:0] sat_sign(
    input logic [CompW-1:0] q,
    input logic [NumW-1:0]  rem,
    input logic             neg,
    input logic             zero
  );
    logic [UnitW-1:0] m;
    m = ((q > UnitOne) || (rem != '0 && q >= UnitOne)) ? UnitOne : q;
    if (zero) m = '0;
    return neg ? UnitW'(-m) : m;
  endfunction

  assign qx_s = sat_sign(dv_end.qx, dv_end.rx, dv_end.tag.neg[0], dv_end.tag.zero);
  assign qy_s = sat_sign(dv_end.qy, dv_end.ry, dv_end.tag.neg[1], dv_end.tag.zero);
  assign qz_s = sat_sign(dv_end.qz, dv_end.rz, dv_end.tag.neg[2], dv_end.tag.zero);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= 1'b0;
      vld_sh_q <= '0;
    end else begin
      done_q   <= dv_end.tag.vld;
      vld_sh_q <= {vld_sh_q[DepthDefault-2:0], start};
    end
  end

  always_ff @(posedge clk_i) begin
    ux_q   <= qx_s;
    uy_q   <= qy_s;
    uz_q   <= qz_s;
    len_q  <= dv_end.tag.zero ? '0 : dv_end.len;
    unit_q <= dv_end.tag.unit;
    zero_q <= dv_end.tag.zero;
  end

  assign done_o        = done_q;
  assign unit_x_o      = ux_q;
  assign unit_y_o      = uy_q;
  assign unit_z_o      = uz_q;
  assign length_fx_o   = len_q;
  assign is_unit_o     = unit_q;
  assign zero_vector_o = zero_q;

  assign units_clr = (unit_x_o == '0) && (unit_y_o == '0) && (unit_z_o == '0) &&
                     (length_fx_o == '0);

  `ASSERT_IMPL(a_done_tracks, clk_i, rst_ni, done_o == vld_sh_q[DepthDefault-1], "done out of step")
  `ASSERT_IMPL(a_zero_units, clk_i, rst_ni, !(done_o && zero_vector_o) || units_clr, "zero units")
  `ASSERT_IMPL(a_flags_excl, clk_i, rst_ni, !(done_o && zero_vector_o && is_unit_o), "flags both set")
  `ASSERT_NEXT(a_never_busy, clk_i, rst_ni, 1'b1, !busy, "busy raised")
endmodule
`default_nettype wire
